/* rtl/msf_pkg.sv */
// ----------------------------------------------------------------------------
// msf_pkg
// shared types and constants for the map sample to float32 unit
// ----------------------------------------------------------------------------
package msf_pkg;

    localparam int unsigned AddrWidth = 4;

    typedef enum logic [2:0] {
        MODE_BYTE   = 3'd0,
        MODE_SHORT  = 3'd1,
        MODE_FLOAT  = 3'd2,
        MODE_USHORT = 3'd3,
        MODE_HALF   = 3'd4
    } t_mode;

    localparam logic [AddrWidth-1:0] ADDR_MODE       = 4'h0;
    localparam logic [AddrWidth-1:0] ADDR_SIGNED     = 4'h4;
    localparam logic [AddrWidth-1:0] ADDR_INT_SWAP   = 4'h8;
    localparam logic [AddrWidth-1:0] ADDR_FLOAT_SWAP = 4'hc;

    localparam logic [7:0] ExpBiasInt  = 8'd127;
    localparam logic [7:0] ExpBiasHalf = 8'd112;

    // stage 1 to stage 2 record
    typedef struct packed {
        logic        is_int;
        logic        is_half;
        logic        is_float;
        logic        neg;
        logic [15:0] mag;
        logic [15:0] half;
        logic [31:0] fbits;
        logic        sect;
    } t_dec;

    // stage 2 to stage 3 record
    typedef struct packed {
        logic        is_int;
        logic        is_half;
        logic        is_float;
        logic        neg;
        logic [15:0] mag;
        logic [3:0]  lead;
        logic        mag_zero;
        logic [15:0] half;
        logic [31:0] fbits;
        logic        sect;
    } t_norm;

    // position of the leading one in a 16-bit value
    function automatic logic [3:0] lead_one(input logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/map_sample_to_float32_unit.sv */
// ----------------------------------------------------------------------------
// map_sample_to_float32_unit
// converts raw map samples to ieee single precision bit patterns
//
// channel   signals                                   role
// input     i_valid/o_ready, i_raw_bytes, i_section_end  sample in
// output    o_valid/i_ready, o_float_bits, o_section_end_out  result out
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  registers
//
// one item per cycle sustained while the output is not stalled
// three register stages: decode, leading one search, pack
// synchronous active low reset clears valid bits and config registers
// a stall holds every stage that is full; empty stages still fill
// ----------------------------------------------------------------------------
module map_sample_to_float32_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_raw_bytes,
    input  logic                          i_section_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_float_bits,
    output logic                          o_section_end_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msf_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    logic [2:0] mode;
    logic       sgn, iswp, fswp;

    msf_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready,
        .o_mode(mode), .o_signed(sgn), .o_int_swap(iswp), .o_float_swap(fswp)
    );

    msf_datapath u_dp (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_raw_bytes, .i_section_end,
        .i_mode(mode), .i_signed(sgn), .i_int_swap(iswp), .i_float_swap(fswp),
        .o_valid, .i_ready, .o_float_bits, .o_section_end_out
    );
endmodule

/* rtl/msf_regs.sv */
// ----------------------------------------------------------------------------
// msf_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module msf_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msf_pkg::AddrWidth-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [2:0]                      o_mode,
    output logic                            o_signed,
    output logic                            o_int_swap,
    output logic                            o_float_swap
);
    logic [2:0] r_mode;
    logic       r_signed;
    logic       r_int_swap;
    logic       r_float_swap;
    logic       wr;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= msf_pkg::MODE_FLOAT;
            r_signed     <= 1'b0;
            r_int_swap   <= 1'b0;
            r_float_swap <= 1'b0;
        end else if (wr) begin
            if (paddr == msf_pkg::ADDR_MODE)       r_mode       <= pwdata[2:0];
            if (paddr == msf_pkg::ADDR_SIGNED)     r_signed     <= pwdata[0];
            if (paddr == msf_pkg::ADDR_INT_SWAP)   r_int_swap   <= pwdata[0];
            if (paddr == msf_pkg::ADDR_FLOAT_SWAP) r_float_swap <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == msf_pkg::ADDR_MODE)       prdata = {29'd0, r_mode};
        if (paddr == msf_pkg::ADDR_SIGNED)     prdata = {31'd0, r_signed};
        if (paddr == msf_pkg::ADDR_INT_SWAP)   prdata = {31'd0, r_int_swap};
        if (paddr == msf_pkg::ADDR_FLOAT_SWAP) prdata = {31'd0, r_float_swap};
    end

    assign o_mode       = r_mode;
    assign o_signed     = r_signed;
    assign o_int_swap   = r_int_swap;
    assign o_float_swap = r_float_swap;
endmodule

/* rtl/msf_datapath.sv */
// ----------------------------------------------------------------------------
// msf_datapath
// three stage conversion pipeline: decode, leading one search, pack
// ----------------------------------------------------------------------------
module msf_datapath (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_raw_bytes,
    input  logic        i_section_end,
    input  logic [2:0]  i_mode,
    input  logic        i_signed,
    input  logic        i_int_swap,
    input  logic        i_float_swap,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_float_bits,
    output logic        o_section_end_out
);
    logic          r_v1, r_v2, r_v3;
    msf_pkg::t_dec  r_s1, n_s1;
    msf_pkg::t_norm r_s2, n_s2;
    logic [31:0]   r_bits, n_bits;
    logic          r_sect;
    logic          adv3, adv2, adv1;
    logic [15:0]   ipair, fpair;
    logic [15:0]   mag_sh;
    logic [3:0]    hl;
    logic [7:0]    hexp;
    logic [9:0]    hmant;

    assign adv3 = ~r_v3 | i_ready;
    assign adv2 = ~r_v2 | adv3;
    assign adv1 = ~r_v1 | adv2;
    assign o_ready = adv1;

    // stage 1: byte order and sign
    always_comb begin
        ipair = i_int_swap ? {i_raw_bytes[7:0], i_raw_bytes[15:8]} : i_raw_bytes[15:0];
        fpair = i_float_swap ? {i_raw_bytes[7:0], i_raw_bytes[15:8]} : i_raw_bytes[15:0];
        n_s1 = '0;
        n_s1.half = fpair;
        n_s1.fbits = i_float_swap ? {i_raw_bytes[7:0], i_raw_bytes[15:8],
                                     i_raw_bytes[23:16], i_raw_bytes[31:24]} : i_raw_bytes;
        n_s1.sect = i_section_end;
        unique case (i_mode)
            msf_pkg::MODE_BYTE: begin
                n_s1.is_int = 1'b1;
                n_s1.neg = i_signed & i_raw_bytes[7];
                n_s1.mag = n_s1.neg ? 16'(9'h100 - {1'b0, i_raw_bytes[7:0]})
                                    : {8'd0, i_raw_bytes[7:0]};
            end
            msf_pkg::MODE_SHORT: begin
                n_s1.is_int = 1'b1;
                n_s1.neg = ipair[15];
                n_s1.mag = ipair[15] ? 16'(17'h10000 - {1'b0, ipair}) : ipair;
            end
            msf_pkg::MODE_USHORT: begin
                n_s1.is_int = 1'b1;
                n_s1.mag = ipair;
            end
            msf_pkg::MODE_HALF: n_s1.is_half = 1'b1;
            default: n_s1.is_float = 1'b1;
        endcase
    end

    // stage 2: leading one searches
    always_comb begin
        n_s2.is_int   = r_s1.is_int;
        n_s2.is_half  = r_s1.is_half;
        n_s2.is_float = r_s1.is_float;
        n_s2.neg      = r_s1.neg;
        n_s2.mag      = r_s1.mag;
        n_s2.half     = r_s1.half;
        n_s2.fbits    = r_s1.fbits;
        n_s2.sect     = r_s1.sect;
        n_s2.mag_zero = (r_s1.is_int & (r_s1.mag == 16'd0));
        // int8 -128 and int16 -32768 give magnitude of 0x80 / 0x8000, still fine
        n_s2.lead = r_s1.is_int ? msf_pkg::lead_one(r_s1.mag)
                                : msf_pkg::lead_one({6'd0, r_s1.half[9:0]});
    end

    // stage 3: pack
    always_comb begin
        mag_sh = r_s2.mag << (4'd15 - r_s2.lead);
        hl     = r_s2.lead;
        hmant  = 10'(r_s2.half[9:0] << (4'd10 - hl));
        hexp   = 8'd0;
        n_bits = r_s2.fbits;
        if (r_s2.is_int) begin
            if (r_s2.mag_zero) begin
                n_bits = 32'd0;
            end else begin
                n_bits = {r_s2.neg, 8'(msf_pkg::ExpBiasInt + {4'd0, r_s2.lead}),
                          mag_sh[14:0], 8'd0};
            end
        end else if (r_s2.is_half) begin
            if (r_s2.half[14:10] == 5'h1f) begin
                n_bits = {r_s2.half[15], 8'hff, r_s2.half[9:0], 13'd0};
            end else if (r_s2.half[14:10] != 5'd0) begin
                hexp = 8'({3'd0, r_s2.half[14:10]} + msf_pkg::ExpBiasHalf);
                n_bits = {r_s2.half[15], hexp, r_s2.half[9:0], 13'd0};
            end else if (r_s2.half[9:0] == 10'd0) begin
                n_bits = {r_s2.half[15], 31'd0};
            end else begin
                // subnormal: exponent 1 - 15 shifted down to the leading one
                hexp = 8'(msf_pkg::ExpBiasHalf - 8'd9 + {4'd0, hl});
                n_bits = {r_s2.half[15], hexp, hmant, 13'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) r_s1 <= n_s1;
        if (adv2 && r_v1)    r_s2 <= n_s2;
        if (adv3 && r_v2) begin
            r_bits <= n_bits;
            r_sect <= r_s2.sect;
        end
    end

    assign o_valid           = r_v3;
    assign o_float_bits      = r_bits;
    assign o_section_end_out = r_sect;
endmodule

/* rtl/msf_checker.sv */
// ----------------------------------------------------------------------------
// msf_checker
// port level checks for the map sample to float32 unit
// ----------------------------------------------------------------------------
module msf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_float_bits,
    input logic        pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_float_bits))
        else $error("output item changed while stalled");

    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output drains");

    // with no input and the output moving, the pipeline drains and no item appears
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_valid && (!o_valid || i_ready)) [*3] |=> !o_valid)
        else $error("item appeared without input");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind map_sample_to_float32_unit msf_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_float_bits, .pready
);
